/* src/fpi_pkg.sv */
// fpi_pkg: shared constants, codes, types for the fictitious play iteration block.
// No dependencies; imported by every module of the block except fpi_ram.
`timescale 1ns / 1ps
`default_nettype none

package fpi_pkg;

   localparam int MAX_PLAYERS_DEF = 4;
   localparam int MAX_ACTIONS_DEF = 64;
   localparam int MAX_JOINT_DEF   = 4096;
   localparam int WEIGHT_BITS_DEF = 40;

   localparam int OP_W       = 3;
   localparam int PLAYER_W   = 2;
   localparam int JIDX_W     = 12;
   localparam int ACTION_W   = 6;
   localparam int UTIL_W     = 16;
   localparam int OUT_W      = 40;
   localparam int STATUS_W   = 2;
   localparam int NP_W       = 3;
   localparam int NA_W       = 7;
   localparam int CSR_W      = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   localparam logic [OP_W-1:0] OP_WRITE_UTIL = 3'd0;
   localparam logic [OP_W-1:0] OP_ITERATE    = 3'd1;
   localparam logic [OP_W-1:0] OP_RD_JOINT   = 3'd2;
   localparam logic [OP_W-1:0] OP_RD_MARG    = 3'd3;
   localparam logic [OP_W-1:0] OP_RESTART    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_CFG = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_PICK = 2'd2;

   localparam logic CSR_NUM_PLAYERS = 1'b0;
   localparam logic CSR_NUM_ACTIONS = 1'b1;

   typedef struct packed {
      logic accept;
      logic cfg_init;
      logic cfg_step;
      logic sweep_start;
      logic sweep_step;
      logic tot_start;
      logic issue;
      logic floor_load;
      logic p_init;
      logic cmp;
      logic emit_err;
      logic emit_rd;
      logic emit_it;
      logic mrd;
      logic mwr;
      logic jrd;
      logic jwr;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic cfg_done;
      logic cfg_ok;
      logic sweep_end;
      logic issue_end;
      logic pipe_empty;
      logic a_last;
      logic p_last;
      logic all_ok;
   } stat_type;

   typedef enum logic [16:0] {
      S_CLEAR = 17'h00001,
      S_IDLE  = 17'h00002,
      S_RDO   = 17'h00004,
      S_CFG   = 17'h00008,
      S_ERR   = 17'h00010,
      S_RST   = 17'h00020,
      S_TOT   = 17'h00040,
      S_TOTW  = 17'h00080,
      S_PINIT = 17'h00100,
      S_SUM   = 17'h00200,
      S_SUMW  = 17'h00400,
      S_CMP   = 17'h00800,
      S_EMIT  = 17'h01000,
      S_MRD   = 17'h02000,
      S_MWR   = 17'h04000,
      S_JRD   = 17'h08000,
      S_JWR   = 17'h10000
   } state_type;

endpackage

`default_nettype wire

/* src/fpi_ram.sv */
// fpi_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fpi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

/* src/fpi_datapath.sv */
// fpi_datapath: config registers, weight and utility memories, sum pipeline,
// best response tracking and result register. Depends on fpi_pkg, fpi_ram.
`timescale 1ns / 1ps
`default_nettype none

module fpi_datapath import fpi_pkg::*; #(
   parameter int MAX_PLAYERS = MAX_PLAYERS_DEF,
   parameter int MAX_ACTIONS = MAX_ACTIONS_DEF,
   parameter int MAX_JOINT   = MAX_JOINT_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata,
   input  wire logic [OP_W-1:0]            req_op,
   input  wire logic [PLAYER_W-1:0]        req_player,
   input  wire logic [JIDX_W-1:0]          req_joint_index,
   input  wire logic [ACTION_W-1:0]        req_action,
   input  wire logic signed [UTIL_W-1:0]   req_utility,
   input  wire cmd_type                    cmd,
   output      stat_type                   stat,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [PLAYER_W-1:0]        rsp_for_player,
   output      logic [ACTION_W-1:0]        rsp_pick_action,
   output      logic [OUT_W-1:0]           rsp_weight,
   output      logic [STATUS_W-1:0]        rsp_status,
   output      logic                       rsp_last
);

   localparam int WB     = WEIGHT_BITS;
   localparam int JA_W   = $clog2(MAX_JOINT);
   localparam int JC_W   = $clog2(MAX_JOINT + 1);
   localparam int UA_W   = $clog2(MAX_PLAYERS * MAX_JOINT);
   localparam int MDEPTH = MAX_PLAYERS * MAX_ACTIONS;
   localparam int MA_W   = $clog2(MDEPTH);
   localparam int PI_W   = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
   localparam int PC_W   = $clog2(MAX_PLAYERS + 1);
   localparam int AI_W   = $clog2(MAX_ACTIONS);
   localparam int SW_N   = (MAX_JOINT > MDEPTH) ? MAX_JOINT : MDEPTH;
   localparam int SW_W   = $clog2(SW_N);
   localparam int PROD_W = WB + UTIL_W + 1;
   localparam int ACC_W  = WB + JC_W + UTIL_W + 1;

   function automatic logic [WB-1:0] sat_add(input logic [WB-1:0] a, input logic [JC_W-1:0] b);
      logic [WB:0] s;
      s = {1'b0, a} + (WB + 1)'(b);
      sat_add = s[WB] ? '1 : s[WB-1:0];
   endfunction

   // configuration
   logic [NP_W-1:0] np_ff;
   logic [NA_W-1:0] na_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= 3'd2;
         na_ff <= 7'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_PLAYERS: np_ff <= csr_wdata[NP_W-1:0];
            CSR_NUM_ACTIONS: na_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // memories
   logic            jw_we, jw_re, mw_we, mw_re, ut_we, ut_re;
   logic [JA_W-1:0] jw_waddr, jw_raddr;
   logic [MA_W-1:0] mw_waddr, mw_raddr;
   logic [UA_W-1:0] ut_waddr, ut_raddr;
   logic [WB-1:0]   jw_wdata, jw_rdata, mw_wdata, mw_rdata;
   logic [UTIL_W-1:0] ut_rdata;

   fpi_ram #(.WIDTH(WB), .DEPTH(MAX_JOINT)) u_joint (
      .clock(clock), .we(jw_we), .waddr(jw_waddr), .wdata(jw_wdata),
      .re(jw_re), .raddr(jw_raddr), .rdata(jw_rdata));

   fpi_ram #(.WIDTH(WB), .DEPTH(MDEPTH)) u_marg (
      .clock(clock), .we(mw_we), .waddr(mw_waddr), .wdata(mw_wdata),
      .re(mw_re), .raddr(mw_raddr), .rdata(mw_rdata));

   fpi_ram #(.WIDTH(UTIL_W), .DEPTH(MAX_PLAYERS * MAX_JOINT)) u_util (
      .clock(clock), .we(ut_we), .waddr(ut_waddr), .wdata(req_utility),
      .re(ut_re), .raddr(ut_raddr), .rdata(ut_rdata));

   // joint count and digit strides
   logic [JC_W-1:0]      cur_ff, marg_ff, jc;
   logic [JC_W-1:0]      pw_ff [MAX_PLAYERS];
   logic [PC_W-1:0]      kc_ff;
   logic                 bad_ff;
   logic [JC_W+NA_W-1:0] nxt;

   assign jc  = cur_ff;
   assign nxt = (JC_W + NA_W)'(cur_ff) * (JC_W + NA_W)'(na_ff);

   always_ff @(posedge clock) begin
      if (cmd.cfg_init) begin
         cur_ff <= JC_W'(1);
         kc_ff  <= '0;
         bad_ff <= (np_ff == '0) || (32'(np_ff) > MAX_PLAYERS) ||
                   (na_ff == '0) || (32'(na_ff) > MAX_ACTIONS);
      end else if (cmd.cfg_step) begin
         pw_ff[kc_ff[PI_W-1:0]] <= cur_ff;
         if (32'(kc_ff) + 1 == 32'(np_ff)) begin
            marg_ff <= cur_ff;
         end
         if (32'(nxt) > MAX_JOINT) begin
            bad_ff <= 1'b1;
         end
         cur_ff <= JC_W'(nxt);
         kc_ff  <= kc_ff + PC_W'(1);
      end
   end

   // clearing / restart sweep
   logic [SW_W-1:0] k_ff;
   logic [PC_W-1:0] mp_ff;
   logic [AI_W-1:0] ma_ff;
   logic            restart_ff;
   logic [WB-1:0]   mw_init;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff       <= '0;
         mp_ff      <= '0;
         ma_ff      <= '0;
         restart_ff <= 1'b0;
      end else if (cmd.sweep_start) begin
         k_ff       <= '0;
         mp_ff      <= '0;
         ma_ff      <= '0;
         restart_ff <= 1'b1;
      end else if (cmd.sweep_step) begin
         k_ff <= k_ff + SW_W'(1);
         if (32'(ma_ff) == MAX_ACTIONS - 1) begin
            ma_ff <= '0;
            mp_ff <= mp_ff + PC_W'(1);
         end else begin
            ma_ff <= ma_ff + AI_W'(1);
         end
      end
   end

   assign mw_init = (restart_ff && (32'(mp_ff) < 32'(np_ff)) && (32'(ma_ff) < 32'(na_ff)))
                    ? WB'(marg_ff) : '0;

   // weighted sum pipeline
   logic [JC_W-1:0]          i_ff, apw_ff, idx_ff, ni;
   logic [AI_W-1:0]          dig_ff [MAX_PLAYERS];
   logic [AI_W-1:0]          dig_in [MAX_PLAYERS];
   logic [NA_W-1:0]          a_ff, cur_pick_ff;
   logic [NA_W-1:0]          pick_ff [MAX_PLAYERS];
   logic                     found_ff [MAX_PLAYERS];
   logic [PI_W-1:0]          p_ff;
   logic                     total_ff, v1_ff, v2_ff, cur_found_ff, all_ok_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, best_ff, floor_ff;
   logic signed [WB:0]       wj;
   logic signed [UTIL_W-1:0] us;
   logic                     a_last, p_last, better, sum_clr;
   logic [MA_W-1:0]          madr_p;

   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int k = 0; k < MAX_PLAYERS; k++) begin
         dig_in[k] = dig_ff[k];
         if (carry && (k < 32'(np_ff))) begin
            if (32'(dig_ff[k]) + 1 == 32'(na_ff)) begin
               dig_in[k] = '0;
            end else begin
               dig_in[k] = dig_ff[k] + AI_W'(1);
               carry     = 1'b0;
            end
         end
      end
   end

   assign ni = JC_W'(32'(i_ff) - 32'(dig_ff[p_ff]) * 32'(pw_ff[p_ff]) + 32'(apw_ff));
   assign wj = $signed({1'b0, jw_rdata});
   assign us = $signed(ut_rdata);
   assign prod_in = total_ff ? PROD_W'(wj) : wj * us;
   assign a_last  = (32'(a_ff) + 1 == 32'(na_ff));
   assign p_last  = (32'(p_ff) + 1 == 32'(np_ff));
   assign better  = (acc_ff > best_ff);
   assign sum_clr = cmd.tot_start | cmd.p_init | (cmd.cmp & ~a_last);
   assign madr_p  = MA_W'(32'(p_ff) * MAX_ACTIONS + 32'(pick_ff[p_ff]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prod_ff <= prod_in;
      end
      if (sum_clr) begin
         i_ff   <= '0;
         acc_ff <= '0;
         for (int k = 0; k < MAX_PLAYERS; k++) begin
            dig_ff[k] <= '0;
         end
      end else begin
         if (cmd.issue) begin
            i_ff <= i_ff + JC_W'(1);
            for (int k = 0; k < MAX_PLAYERS; k++) begin
               dig_ff[k] <= dig_in[k];
            end
         end
         if (v2_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tot_start) begin
         total_ff  <= 1'b1;
         p_ff      <= '0;
         all_ok_ff <= 1'b1;
         idx_ff    <= '0;
      end
      if (cmd.floor_load) begin
         floor_ff <= -((acc_ff <<< 11) + (acc_ff <<< 9));
      end
      if (cmd.p_init) begin
         total_ff     <= 1'b0;
         best_ff      <= floor_ff;
         a_ff         <= '0;
         apw_ff       <= '0;
         cur_found_ff <= 1'b0;
         cur_pick_ff  <= '0;
      end
      if (cmd.cmp) begin
         if (better) begin
            best_ff      <= acc_ff;
            cur_found_ff <= 1'b1;
            cur_pick_ff  <= a_ff;
         end
         if (a_last) begin
            found_ff[p_ff] <= cur_found_ff | better;
            pick_ff[p_ff]  <= better ? a_ff : cur_pick_ff;
            if (!(cur_found_ff | better)) begin
               all_ok_ff <= 1'b0;
            end
            p_ff <= p_last ? '0 : p_ff + PI_W'(1);
         end else begin
            a_ff   <= a_ff + NA_W'(1);
            apw_ff <= apw_ff + pw_ff[p_ff];
         end
      end
      if (cmd.emit_it) begin
         p_ff <= p_last ? '0 : p_ff + PI_W'(1);
      end
      if (cmd.mwr) begin
         idx_ff <= idx_ff + JC_W'(32'(pick_ff[p_ff]) * 32'(pw_ff[p_ff]));
         p_ff   <= p_last ? '0 : p_ff + PI_W'(1);
      end
   end

   // read requests
   logic [PLAYER_W-1:0] player_ff;
   logic                rd_joint_ff, rd_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         player_ff   <= req_player;
         rd_joint_ff <= (req_op == OP_RD_JOINT);
         rd_ok_ff    <= (req_op == OP_RD_JOINT) ? (32'(req_joint_index) < MAX_JOINT) :
                        ((32'(req_player) < MAX_PLAYERS) && (32'(req_action) < MAX_ACTIONS));
      end
   end

   always_comb begin
      jw_re    = cmd.issue | cmd.jrd | (cmd.accept & (req_op == OP_RD_JOINT));
      jw_raddr = cmd.issue ? i_ff[JA_W-1:0] :
                 cmd.jrd   ? idx_ff[JA_W-1:0] : JA_W'(req_joint_index);
      jw_we    = (cmd.sweep_step & (32'(k_ff) < MAX_JOINT)) | cmd.jwr;
      jw_waddr = cmd.jwr ? idx_ff[JA_W-1:0] : k_ff[JA_W-1:0];
      jw_wdata = cmd.jwr ? sat_add(jw_rdata, jc) : WB'(1);

      mw_re    = cmd.mrd | (cmd.accept & (req_op == OP_RD_MARG));
      mw_raddr = cmd.mrd ? madr_p :
                 MA_W'(32'(req_player) * MAX_ACTIONS + 32'(req_action));
      mw_we    = (cmd.sweep_step & (32'(k_ff) < MDEPTH)) | cmd.mwr;
      mw_waddr = cmd.mwr ? madr_p : k_ff[MA_W-1:0];
      mw_wdata = cmd.mwr ? sat_add(mw_rdata, jc) : mw_init;

      ut_we    = cmd.accept & (req_op == OP_WRITE_UTIL) &
                 (32'(req_player) < MAX_PLAYERS) & (32'(req_joint_index) < MAX_JOINT);
      ut_waddr = UA_W'(32'(req_player) * MAX_JOINT + 32'(req_joint_index));
      ut_re    = cmd.issue & ~total_ff;
      ut_raddr = UA_W'(32'(p_ff) * MAX_JOINT + 32'(ni));
   end

   // result register
   logic                  out_valid_ff, out_free;
   logic [WB-1:0]         wsel;
   logic [OUT_W+WB-1:0]   wx;

   assign out_free = ~out_valid_ff | rsp_ready;
   assign wsel     = rd_ok_ff ? (rd_joint_ff ? jw_rdata : mw_rdata) : '0;
   assign wx       = {{OUT_W{1'b0}}, wsel};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_err | cmd.emit_rd | cmd.emit_it) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         rsp_for_player  <= '0;
         rsp_pick_action <= '0;
         rsp_weight      <= '0;
         rsp_status      <= ST_BAD_CFG;
         rsp_last        <= 1'b1;
      end else if (cmd.emit_rd) begin
         rsp_for_player  <= player_ff;
         rsp_pick_action <= '0;
         rsp_weight      <= wx[OUT_W-1:0];
         rsp_status      <= ST_OK;
         rsp_last        <= 1'b1;
      end else if (cmd.emit_it) begin
         rsp_for_player  <= PLAYER_W'(32'(p_ff));
         rsp_pick_action <= found_ff[p_ff] ? ACTION_W'(pick_ff[p_ff]) : '0;
         rsp_weight      <= '0;
         rsp_status      <= found_ff[p_ff] ? ST_OK : ST_NO_PICK;
         rsp_last        <= p_last;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_comb begin
      stat.out_free   = out_free;
      stat.cfg_done   = bad_ff | (32'(kc_ff) == 32'(np_ff));
      stat.cfg_ok     = ~bad_ff;
      stat.sweep_end  = (32'(k_ff) == SW_N - 1);
      stat.issue_end  = (i_ff == jc);
      stat.pipe_empty = ~v1_ff & ~v2_ff;
      stat.a_last     = a_last;
      stat.p_last     = p_last;
      stat.all_ok     = all_ok_ff;
   end

endmodule

`default_nettype wire

/* src/fpi_ctrl.sv */
// fpi_ctrl: sequencing state machine; issues datapath commands from status.
// Depends on fpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpi_ctrl import fpi_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   input  wire logic [OP_W-1:0] req_op,
   output      logic            req_tready,
   input  wire stat_type        stat,
   output      cmd_type         cmd
);

   state_type       state_ff, state_in;
   logic [OP_W-1:0] op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= req_op;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff) inside
         S_CLEAR, S_RST: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_end) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (req_op) inside
                  OP_ITERATE, OP_RESTART: begin
                     cmd.cfg_init = 1'b1;
                     state_in     = S_CFG;
                  end
                  OP_RD_JOINT, OP_RD_MARG: state_in = S_RDO;
                  default: ;
               endcase
            end
         end
         S_RDO: begin
            if (stat.out_free) begin
               cmd.emit_rd = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_CFG: begin
            if (!stat.cfg_done) begin
               cmd.cfg_step = 1'b1;
            end else if (!stat.cfg_ok) begin
               state_in = S_ERR;
            end else if (op_ff == OP_RESTART) begin
               cmd.sweep_start = 1'b1;
               state_in        = S_RST;
            end else begin
               cmd.tot_start = 1'b1;
               state_in      = S_TOT;
            end
         end
         S_ERR: begin
            if (stat.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TOT: begin
            if (stat.issue_end) state_in = S_TOTW;
            else cmd.issue = 1'b1;
         end
         S_TOTW: begin
            if (stat.pipe_empty) begin
               cmd.floor_load = 1'b1;
               state_in       = S_PINIT;
            end
         end
         S_PINIT: begin
            cmd.p_init = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            if (stat.issue_end) state_in = S_SUMW;
            else cmd.issue = 1'b1;
         end
         S_SUMW: begin
            if (stat.pipe_empty) state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            if (!stat.a_last) state_in = S_SUM;
            else if (stat.p_last) state_in = S_EMIT;
            else state_in = S_PINIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_it = 1'b1;
               if (stat.p_last) state_in = stat.all_ok ? S_MRD : S_IDLE;
            end
         end
         S_MRD: begin
            cmd.mrd  = 1'b1;
            state_in = S_MWR;
         end
         S_MWR: begin
            cmd.mwr  = 1'b1;
            state_in = stat.p_last ? S_JRD : S_MRD;
         end
         S_JRD: begin
            cmd.jrd  = 1'b1;
            state_in = S_JWR;
         end
         S_JWR: begin
            cmd.jwr  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* src/fictitious_play_iteration.sv */
// fictitious_play_iteration: top level, stream ports, word packing, assertions.
// Depends on fpi_pkg, fpi_ctrl, fpi_datapath (and fpi_ram below it).
`timescale 1ns / 1ps
`default_nettype none

// Fictitious play best-response engine. One request word at a time is taken; a
// finished result waits in an output register while the next word is taken; a new
// result is loaded only once the previous word has been taken. Each weighted sum of
// an iterate streams the joint weight and utility memories at one element per cycle
// through a read, multiply, accumulate pipeline. After reset and after each restart
// the weight memories are swept, during which no request is taken (configuration
// writes still are).
module fictitious_play_iteration import fpi_pkg::*; #(
   parameter int MAX_PLAYERS = MAX_PLAYERS_DEF,
   parameter int MAX_ACTIONS = MAX_ACTIONS_DEF,
   parameter int MAX_JOINT   = MAX_JOINT_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // player, joint_index, action, utility
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  wire logic [OP_W-1:0]       req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // for_player, pick_action, weight, status
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tlast
);

   cmd_type  cmd;
   stat_type stat;

   logic [PLAYER_W-1:0] for_player;
   logic [ACTION_W-1:0] pick_action;
   logic [OUT_W-1:0]    weight;
   logic [STATUS_W-1:0] status;

   fpi_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_op(req_tuser),
      .req_tready(req_tready), .stat(stat), .cmd(cmd));

   fpi_datapath #(
      .MAX_PLAYERS(MAX_PLAYERS), .MAX_ACTIONS(MAX_ACTIONS),
      .MAX_JOINT(MAX_JOINT), .WEIGHT_BITS(WEIGHT_BITS)
   ) u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_op(req_tuser),
      .req_player(req_tdata[1:0]),
      .req_joint_index(req_tdata[13:2]),
      .req_action(req_tdata[19:14]),
      .req_utility(req_tdata[35:20]),
      .cmd(cmd), .stat(stat),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_for_player(for_player), .rsp_pick_action(pick_action),
      .rsp_weight(weight), .rsp_status(status), .rsp_last(rsp_tlast));

   assign rsp_tdata = {6'd0, status, weight, pick_action, for_player};

`ifndef NO_ASSERTIONS
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !stat.issue_end)
      else $error("element issued past joint count");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_err || cmd.emit_rd || cmd.emit_it) |-> stat.out_free)
      else $error("result loaded over a pending word");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> stat.pipe_empty)
      else $error("request taken while sum pipeline busy");
`endif

endmodule

`default_nettype wire
